>>> hw/rtl/dcp_pkg.sv
// ----------------------------------------------------------------------------
// dcp_pkg
// Shared constants and types for the distance cutoff pair finder.
// ----------------------------------------------------------------------------
package dcp_pkg;

  localparam int MAX_POINTS     = 64;
  localparam int COORD_BITS     = 16;
  localparam int POS_BITS       = 16;
  localparam int CUTOFF_BITS    = 36;
  localparam int IDX_OUT_BITS   = 6;
  localparam int CMD_FIFO_DEPTH = 2;
  localparam int OUT_FIFO_DEPTH = 8;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

>>> hw/rtl/dcp_ram.sv
// ----------------------------------------------------------------------------
// dcp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dcp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/dcp_fifo.sv
// ----------------------------------------------------------------------------
// dcp_fifo
// Small synchronous FIFO, power-of-two depth, head entry shown on rdata.
// ----------------------------------------------------------------------------
module dcp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [WIDTH-1:0]   wdata,
  input  logic               pop,
  output logic [WIDTH-1:0]   rdata,
  output dcp_pkg::fifo_stat_t stat
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW:0]      wptr;
  logic [AW:0]      rptr;

  assign stat.empty = (wptr == rptr);
  assign stat.full  = (wptr[AW-1:0] == rptr[AW-1:0]) && (wptr[AW] != rptr[AW]);
  assign rdata      = mem[rptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + (AW+1)'(1);
      end
      if (pop) begin
        rptr <= rptr + (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr[AW-1:0]] <= wdata;
    end
  end

endmodule

>>> hw/rtl/dcp_front.sv
// ----------------------------------------------------------------------------
// dcp_front
// Accepts points, assigns store indices and flags dropped points.
// ----------------------------------------------------------------------------
module dcp_front #(
  parameter int MAX_POINTS = dcp_pkg::MAX_POINTS,
  parameter int COORD_BITS = dcp_pkg::COORD_BITS,
  localparam int IW = $clog2(MAX_POINTS),
  localparam int CW = $clog2(MAX_POINTS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          point_valid,
  output logic                          point_stall,
  input  logic [dcp_pkg::POS_BITS-1:0]  pos_x,
  input  logic [dcp_pkg::POS_BITS-1:0]  pos_y,
  input  logic [dcp_pkg::POS_BITS-1:0]  pos_z,
  input  logic                          new_set,
  input  dcp_pkg::fifo_stat_t           cmd_stat,
  output logic                          cmd_push,
  output logic [COORD_BITS-1:0]         cmd_x,
  output logic [COORD_BITS-1:0]         cmd_y,
  output logic [COORD_BITS-1:0]         cmd_z,
  output logic [IW-1:0]                 cmd_index,
  output logic                          cmd_full
);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  generate
    if (COORD_BITS <= dcp_pkg::POS_BITS) begin : g_narrow
      assign cmd_x = pos_x[COORD_BITS-1:0];
      assign cmd_y = pos_y[COORD_BITS-1:0];
      assign cmd_z = pos_z[COORD_BITS-1:0];
    end else begin : g_wide
      assign cmd_x = COORD_BITS'(pos_x);
      assign cmd_y = COORD_BITS'(pos_y);
      assign cmd_z = COORD_BITS'(pos_z);
    end
  endgenerate

  assign point_stall = cmd_stat.full;
  assign cmd_push    = point_valid && !cmd_stat.full;

  always_comb begin
    count_next = count;
    cmd_index  = '0;
    cmd_full   = 1'b0;
    if (new_set) begin
      count_next = CW'(1);
    end else if (count == CW'(MAX_POINTS)) begin
      cmd_full = 1'b1;
    end else begin
      cmd_index  = count[IW-1:0];
      count_next = count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd_push) begin
      count <= count_next;
    end
  end

endmodule

>>> hw/rtl/dcp_back.sv
// ----------------------------------------------------------------------------
// dcp_back
// Sweeps the point store for each command, squared-distance pipeline,
// credit-gated issue into the result FIFO.
// ----------------------------------------------------------------------------
module dcp_back #(
  parameter int MAX_POINTS = dcp_pkg::MAX_POINTS,
  parameter int COORD_BITS = dcp_pkg::COORD_BITS,
  localparam int IW  = $clog2(MAX_POINTS),
  localparam int PW  = 3 * COORD_BITS,
  localparam int SQW = 2 * COORD_BITS,
  localparam int SUMW = (SQW + 2 > dcp_pkg::CUTOFF_BITS) ? SQW + 2 : dcp_pkg::CUTOFF_BITS,
  localparam int OW  = 2 * dcp_pkg::IDX_OUT_BITS + 3
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [COORD_BITS-1:0]             cmd_x,
  input  logic [COORD_BITS-1:0]             cmd_y,
  input  logic [COORD_BITS-1:0]             cmd_z,
  input  logic [IW-1:0]                     cmd_index,
  input  logic                              cmd_full,
  input  dcp_pkg::fifo_stat_t               cmd_stat,
  output logic                              cmd_pop,
  input  logic [dcp_pkg::CUTOFF_BITS-1:0]   cutoff,
  output logic                              ram_we,
  output logic [IW-1:0]                     ram_waddr,
  output logic [PW-1:0]                     ram_wdata,
  output logic [IW-1:0]                     ram_raddr,
  input  logic [PW-1:0]                     ram_rdata,
  output logic                              pair_valid,
  input  logic                              pair_stall,
  output logic [dcp_pkg::IDX_OUT_BITS-1:0]  earlier_index,
  output logic [dcp_pkg::IDX_OUT_BITS-1:0]  new_index,
  output logic                              is_pair,
  output logic                              store_full,
  output logic                              last
);

  localparam int OUT_DEPTH = dcp_pkg::OUT_FIFO_DEPTH;
  localparam int RW = $clog2(OUT_DEPTH + 1);
  localparam int XW = dcp_pkg::IDX_OUT_BITS;

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_MARK} state_t;

  state_t                state;
  logic [IW-1:0]         idx;
  logic [COORD_BITS-1:0] cur_x, cur_y, cur_z;
  logic [IW-1:0]         cur_newi;
  logic                  cur_full;

  logic [RW-1:0] rsv;
  logic          credit_ok;
  logic          issue_cmp;
  logic          issue_mark;

  logic                  t1_valid, t1_mark, t1_full;
  logic [IW-1:0]         t1_idx, t1_newi;
  logic [COORD_BITS-1:0] t1_x, t1_y, t1_z;

  logic                  t2_valid, t2_mark, t2_full;
  logic [IW-1:0]         t2_idx, t2_newi;
  logic [COORD_BITS-1:0] t2_ax, t2_ay, t2_az;

  logic                  t3_valid, t3_mark, t3_full;
  logic [IW-1:0]         t3_idx, t3_newi;
  logic [SQW-1:0]        t3_sx, t3_sy, t3_sz;

  logic [SUMW-1:0] d2;
  logic            hit;
  logic            opush;
  logic            odrop;
  logic            opop;
  logic [OW-1:0]   owdata;
  logic [OW-1:0]   ordata;
  dcp_pkg::fifo_stat_t ostat;

  function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
    logic [COORD_BITS:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    if (d[COORD_BITS]) begin
      d = -d;
    end
    return d[COORD_BITS-1:0];
  endfunction

  assign credit_ok  = (rsv < RW'(OUT_DEPTH));
  assign cmd_pop    = (state == S_IDLE) && !cmd_stat.empty;
  assign issue_cmp  = (state == S_SWEEP) && credit_ok;
  assign issue_mark = (state == S_MARK) && credit_ok;

  assign ram_we    = cmd_pop && !cmd_full;
  assign ram_waddr = cmd_index;
  assign ram_wdata = {cmd_x, cmd_y, cmd_z};
  assign ram_raddr = idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            cur_x    <= cmd_x;
            cur_y    <= cmd_y;
            cur_z    <= cmd_z;
            cur_newi <= cmd_index;
            cur_full <= cmd_full;
            idx      <= '0;
            state    <= (cmd_full || cmd_index == '0) ? S_MARK : S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (credit_ok) begin
            if (idx + IW'(1) == cur_newi) begin
              state <= S_MARK;
            end else begin
              idx <= idx + IW'(1);
            end
          end
        end
        S_MARK: begin
          if (credit_ok) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_valid <= 1'b0;
      t2_valid <= 1'b0;
      t3_valid <= 1'b0;
    end else begin
      t1_valid <= issue_cmp || issue_mark;
      t2_valid <= t1_valid;
      t3_valid <= t2_valid;
    end
  end

  always_ff @(posedge clk) begin
    t1_mark <= issue_mark;
    t1_full <= cur_full;
    t1_idx  <= idx;
    t1_newi <= cur_newi;
    t1_x    <= cur_x;
    t1_y    <= cur_y;
    t1_z    <= cur_z;

    t2_mark <= t1_mark;
    t2_full <= t1_full;
    t2_idx  <= t1_idx;
    t2_newi <= t1_newi;
    t2_ax   <= abs_diff(ram_rdata[PW-1:2*COORD_BITS], t1_x);
    t2_ay   <= abs_diff(ram_rdata[2*COORD_BITS-1:COORD_BITS], t1_y);
    t2_az   <= abs_diff(ram_rdata[COORD_BITS-1:0], t1_z);

    t3_mark <= t2_mark;
    t3_full <= t2_full;
    t3_idx  <= t2_idx;
    t3_newi <= t2_newi;
    t3_sx   <= SQW'(t2_ax) * SQW'(t2_ax);
    t3_sy   <= SQW'(t2_ay) * SQW'(t2_ay);
    t3_sz   <= SQW'(t2_az) * SQW'(t2_az);
  end

  assign d2    = SUMW'(t3_sx) + SUMW'(t3_sy) + SUMW'(t3_sz);
  assign hit   = (d2 != '0) && (d2 < SUMW'(cutoff));
  assign opush = t3_valid && (t3_mark || hit);
  assign odrop = t3_valid && !t3_mark && !hit;

  always_comb begin
    if (t3_mark) begin
      owdata = {XW'(0), XW'(t3_newi), 1'b0, t3_full, 1'b1};
    end else begin
      owdata = {XW'(t3_idx), XW'(t3_newi), 1'b1, 1'b0, 1'b0};
    end
  end

  dcp_fifo #(
    .WIDTH (OW),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (opush),
    .wdata (owdata),
    .pop   (opop),
    .rdata (ordata),
    .stat  (ostat)
  );

  assign pair_valid = !ostat.empty;
  assign opop       = pair_valid && !pair_stall;
  assign {earlier_index, new_index, is_pair, store_full, last} = ordata;

  // reservations cover tokens in flight plus entries held in the result FIFO
  always_ff @(posedge clk) begin
    if (rst) begin
      rsv <= '0;
    end else begin
      rsv <= rsv + RW'(issue_cmp || issue_mark) - RW'(opop) - RW'(odrop);
    end
  end

endmodule

>>> hw/rtl/distance_cutoff_pair_finder.sv
// ----------------------------------------------------------------------------
// distance_cutoff_pair_finder
// Fixed-radius neighbor pair search over a stream of 3-D points.
// ----------------------------------------------------------------------------
// Sweep: each point is compared with the N points already stored (none when the
//   set restarts or the store is full), one store entry a cycle while the result
//   FIFO has credit; the end marker follows the point's pair results.
// Reset: point count and cutoff clear to zero; the store is not cleared.
module distance_cutoff_pair_finder #(
  parameter int MAX_POINTS = dcp_pkg::MAX_POINTS,
  parameter int COORD_BITS = dcp_pkg::COORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              point_valid,
  output logic                              point_stall,
  input  logic [dcp_pkg::POS_BITS-1:0]      pos_x,
  input  logic [dcp_pkg::POS_BITS-1:0]      pos_y,
  input  logic [dcp_pkg::POS_BITS-1:0]      pos_z,
  input  logic                              new_set,
  output logic                              pair_valid,
  input  logic                              pair_stall,
  output logic [dcp_pkg::IDX_OUT_BITS-1:0]  earlier_index,
  output logic [dcp_pkg::IDX_OUT_BITS-1:0]  new_index,
  output logic                              is_pair,
  output logic                              store_full,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dcp_pkg::CUTOFF_BITS-1:0]   cutoff_sq
);

  localparam int IW   = $clog2(MAX_POINTS);
  localparam int PW   = 3 * COORD_BITS;
  localparam int CMDW = PW + IW + 1;

  logic [dcp_pkg::CUTOFF_BITS-1:0] cutoff;

  dcp_pkg::fifo_stat_t   cmd_stat;
  logic                  cmd_push;
  logic                  cmd_pop;
  logic [COORD_BITS-1:0] f_x, f_y, f_z;
  logic [IW-1:0]         f_index;
  logic                  f_full;
  logic [COORD_BITS-1:0] b_x, b_y, b_z;
  logic [IW-1:0]         b_index;
  logic                  b_full;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [PW-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [PW-1:0] ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff <= '0;
    end else if (cfg_valid) begin
      cutoff <= cutoff_sq;
    end
  end

  dcp_front #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .new_set     (new_set),
    .cmd_stat    (cmd_stat),
    .cmd_push    (cmd_push),
    .cmd_x       (f_x),
    .cmd_y       (f_y),
    .cmd_z       (f_z),
    .cmd_index   (f_index),
    .cmd_full    (f_full)
  );

  dcp_fifo #(
    .WIDTH (CMDW),
    .DEPTH (dcp_pkg::CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata ({f_x, f_y, f_z, f_index, f_full}),
    .pop   (cmd_pop),
    .rdata ({b_x, b_y, b_z, b_index, b_full}),
    .stat  (cmd_stat)
  );

  dcp_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dcp_back #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_x         (b_x),
    .cmd_y         (b_y),
    .cmd_z         (b_z),
    .cmd_index     (b_index),
    .cmd_full      (b_full),
    .cmd_stat      (cmd_stat),
    .cmd_pop       (cmd_pop),
    .cutoff        (cutoff),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .pair_valid    (pair_valid),
    .pair_stall    (pair_stall),
    .earlier_index (earlier_index),
    .new_index     (new_index),
    .is_pair       (is_pair),
    .store_full    (store_full),
    .last          (last)
  );

endmodule

>>> hw/rtl/dcp_checker.sv
// ----------------------------------------------------------------------------
// dcp_checker
// Port-level checks on the result stream of the pair finder.
// ----------------------------------------------------------------------------
module dcp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              pair_valid,
  input logic                              pair_stall,
  input logic [dcp_pkg::IDX_OUT_BITS-1:0]  earlier_index,
  input logic [dcp_pkg::IDX_OUT_BITS-1:0]  new_index,
  input logic                              is_pair,
  input logic                              store_full,
  input logic                              last
);

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    pair_valid && pair_stall |=> pair_valid)
    else $error("result valid dropped while stalled");

  a_pair_fields: assert property (@(posedge clk) disable iff (rst)
    pair_valid && is_pair |-> !store_full && !last)
    else $error("pair transaction carries marker flags");

  a_marker_fields: assert property (@(posedge clk) disable iff (rst)
    pair_valid && !is_pair |-> last && earlier_index == '0 && (!store_full || new_index == '0))
    else $error("malformed end marker");

  a_same_item: assert property (@(posedge clk) disable iff (rst)
    (pair_valid && is_pair && !pair_stall) ##1 pair_valid |-> new_index == $past(new_index))
    else $error("result after a pair belongs to another point");

endmodule

bind distance_cutoff_pair_finder dcp_checker u_dcp_checker (.*);
